FILE: src/lfu_lru_pkg.sv
// ----------------------------------------------------------------------------
// lfu_lru_pkg
// Shared types for the LFU cache with LRU tie-break: word formats and FSM states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lfu_lru_pkg;

    localparam int unsigned KEY_W  = 32;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic {
        ACT_GET = 1'b0,
        ACT_PUT = 1'b1
    } t_action;

    typedef struct packed {
        t_action                  action;
        logic signed [KEY_W-1:0]  lookup_key;
        logic signed [DATA_W-1:0] write_value;
    } t_in_word;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
        logic signed [KEY_W-1:0]  evicted_key;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_DECIDE,
        ST_RANK,
        ST_RANK_END,
        ST_RESP
    } t_state;

endpackage

`default_nettype wire

FILE: src/lfu_cache_lru_tiebreak_top.sv
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak_top
// Key-value cache, LFU replacement with LRU tie-break, scanned one entry a cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_stall / i_in_word carries get or put words;
//   output channel o_out_valid / i_out_stall / o_out_word returns one result
//   word per input word, in order. i_cfg_we / i_cfg_wdata set the capacity.
// Sequence:
//   Hit or put: one pass over the entry memories for key match, free slot and
//   victim, a decide step, then one read-modify-write pass over the recency
//   ranks. A get that misses skips the rank pass. Capacity 0 skips the scan
//   and goes straight to the response. One word is in work at a time; the
//   next word is taken once the result has moved into the output register.
// Reset:
//   Clears all valid bits and the occupancy, sets capacity to 16. Entry
//   memories are not cleared; only valid entries are ever used.
// Stall:
//   A result held by i_out_stall stays in the output register; the block can
//   take and finish one more word meanwhile, then waits for the register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfu_cache_lru_tiebreak_top #(
    parameter int unsigned ENTRIES     = 16,
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  lfu_lru_pkg::t_in_word       i_in_word,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output lfu_lru_pkg::t_out_word      o_out_word,
    input  wire                         i_cfg_we,
    input  wire [lfu_lru_pkg::CAP_W-1:0] i_cfg_wdata
);
    import lfu_lru_pkg::*;

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned OW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
    localparam logic [8:0]    ENT_EXT  = 9'(ENTRIES);

    // entry memories
    logic [KEY_W-1:0]       m_key   [ENTRIES];
    logic [DATA_W-1:0]      m_val   [ENTRIES];
    logic [COUNT_WIDTH-1:0] m_cnt   [ENTRIES];
    logic [IW-1:0]          m_rank  [ENTRIES];

    t_state                 r_state, n_state;
    logic [ENTRIES-1:0]     r_valid;
    logic [OW-1:0]          r_occ;
    logic [CAP_W-1:0]       r_capacity;
    logic [IW-1:0]          r_idx;

    t_in_word               r_in;
    t_out_word              r_res;
    logic                   r_out_valid;
    t_out_word              r_out_word;

    // read pipeline
    logic                   r_rd_on;
    logic [IW-1:0]          r_rd_idx;
    logic [KEY_W-1:0]       r_rd_key;
    logic [DATA_W-1:0]      r_rd_val;
    logic [COUNT_WIDTH-1:0] r_rd_cnt;
    logic [IW-1:0]          r_rd_rank;

    // scan results
    logic                   r_found, r_free_found, r_vic_found;
    logic [IW-1:0]          r_fidx, r_free_idx, r_vic_idx;
    logic [DATA_W-1:0]      r_fval;
    logic [COUNT_WIDTH-1:0] r_fcnt, r_vic_cnt;
    logic [IW-1:0]          r_frank, r_vic_rank;
    logic [KEY_W-1:0]       r_vic_key;

    // update plan
    logic [IW-1:0]          r_slot;
    logic [IW-1:0]          r_old_rank;
    logic                   r_all;

    // control
    logic                   w_accept, w_cap_zero, w_out_load, w_scan_issue, w_rank_issue;
    logic                   w_scan_eval, w_rank_eval;
    logic [8:0]             w_cap;

    // decision
    logic                   w_upd, w_all, w_insert, w_free_ins;
    logic [IW-1:0]          w_slot, w_old_rank;
    logic                   w_key_we, w_val_we, w_cnt_we;
    logic [DATA_W-1:0]      w_val_d;
    logic [COUNT_WIDTH-1:0] w_cnt_d, w_cnt_inc;
    t_out_word              w_res;

    // rank update
    logic                   w_rank_we;
    logic [IW-1:0]          w_rank_d;
    logic                   w_rd_vld;

    assign w_cap      = (9'(r_capacity) > ENT_EXT) ? ENT_EXT : 9'(r_capacity);
    assign w_cap_zero = (w_cap == 9'd0);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_rd_vld   = r_valid[r_rd_idx];
    assign w_cnt_inc  = (r_fcnt != '1) ? r_fcnt + 1'b1 : r_fcnt;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_cap_zero ? ST_RESP : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: n_state = ST_DECIDE;
            ST_DECIDE:   n_state = w_upd ? ST_RANK : ST_RESP;
            ST_RANK: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ST_RANK_END;
                end
            end
            ST_RANK_END: n_state = ST_RESP;
            ST_RESP: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall   = 1'b1;
        w_scan_issue = 1'b0;
        w_rank_issue = 1'b0;
        w_scan_eval  = 1'b0;
        w_rank_eval  = 1'b0;
        w_out_load   = 1'b0;
        unique case (r_state)
            ST_IDLE:     o_in_stall = 1'b0;
            ST_SCAN: begin
                w_scan_issue = 1'b1;
                w_scan_eval  = r_rd_on;
            end
            ST_SCAN_END: w_scan_eval = r_rd_on;
            ST_DECIDE:   ;
            ST_RANK: begin
                w_rank_issue = 1'b1;
                w_rank_eval  = r_rd_on;
            end
            ST_RANK_END: w_rank_eval = r_rd_on;
            ST_RESP:     w_out_load = !r_out_valid || !i_out_stall;
            default:     ;
        endcase
    end

    // hit / insert / evict decision, used in the decide cycle
    always_comb begin
        w_upd      = 1'b0;
        w_all      = 1'b0;
        w_insert   = 1'b0;
        w_free_ins = 1'b0;
        w_slot     = r_fidx;
        w_old_rank = r_frank;
        w_key_we   = 1'b0;
        w_val_we   = 1'b0;
        w_cnt_we   = 1'b0;
        w_val_d    = r_in.write_value;
        w_cnt_d    = w_cnt_inc;
        w_res      = '0;
        if (r_found) begin
            w_upd     = 1'b1;
            w_cnt_we  = 1'b1;
            w_val_we  = (r_in.action == ACT_PUT);
            w_res.hit = 1'b1;
            if (r_in.action == ACT_GET) begin
                w_res.read_value = r_fval;
            end
        end else if (r_in.action == ACT_PUT) begin
            if ((9'(r_occ) < w_cap) && r_free_found) begin
                w_upd      = 1'b1;
                w_all      = 1'b1;
                w_insert   = 1'b1;
                w_free_ins = 1'b1;
                w_slot     = r_free_idx;
            end else if (r_vic_found) begin
                w_upd             = 1'b1;
                w_insert          = 1'b1;
                w_slot            = r_vic_idx;
                w_old_rank        = r_vic_rank;
                w_res.evicted     = 1'b1;
                w_res.evicted_key = r_vic_key;
            end
        end
        if (w_insert) begin
            w_key_we = 1'b1;
            w_val_we = 1'b1;
            w_cnt_we = 1'b1;
            w_cnt_d  = COUNT_WIDTH'(1);
        end
    end

    // rank pass: used slot to 0; newer entries age by one, all on a free insert
    always_comb begin
        w_rank_we = 1'b0;
        w_rank_d  = IW'(r_rd_rank + 1'b1);
        if (w_rank_eval) begin
            if (r_rd_idx == r_slot) begin
                w_rank_we = 1'b1;
                w_rank_d  = '0;
            end else if (w_rd_vld && (r_all || (r_rd_rank < r_old_rank))) begin
                w_rank_we = 1'b1;
            end
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DECIDE) begin
            if (w_key_we) begin
                m_key[w_slot] <= r_in.lookup_key;
            end
            if (w_val_we) begin
                m_val[w_slot] <= w_val_d;
            end
            if (w_cnt_we) begin
                m_cnt[w_slot] <= w_cnt_d;
            end
        end
        if (w_rank_we) begin
            m_rank[r_rd_idx] <= w_rank_d;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_key  <= m_key[r_idx];
        r_rd_val  <= m_val[r_idx];
        r_rd_cnt  <= m_cnt[r_idx];
        r_rd_rank <= m_rank[r_idx];
        r_rd_idx  <= r_idx;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_occ       <= '0;
            r_capacity  <= CAP_RESET;
            r_out_valid <= 1'b0;
            r_rd_on     <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state <= n_state;
            r_rd_on <= w_scan_issue || w_rank_issue;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (w_scan_issue || w_rank_issue) begin
                r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end else begin
                r_idx <= '0;
            end
            if ((r_state == ST_DECIDE) && w_insert) begin
                r_valid[w_slot] <= 1'b1;
                if (w_free_ins || (r_occ == '0)) begin
                    r_occ <= r_occ + 1'b1;
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in         <= i_in_word;
            r_res        <= '0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_vic_found  <= 1'b0;
        end
        if (w_scan_eval) begin
            if (w_rd_vld && !r_found && (r_rd_key == r_in.lookup_key)) begin
                r_found <= 1'b1;
                r_fidx  <= r_rd_idx;
                r_fval  <= r_rd_val;
                r_fcnt  <= r_rd_cnt;
                r_frank <= r_rd_rank;
            end
            if (!w_rd_vld && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_rd_idx;
            end
            // lowest count wins, older (higher rank) among equal counts
            if (w_rd_vld && (!r_vic_found || (r_rd_cnt < r_vic_cnt) ||
                             ((r_rd_cnt == r_vic_cnt) && (r_rd_rank > r_vic_rank)))) begin
                r_vic_found <= 1'b1;
                r_vic_idx   <= r_rd_idx;
                r_vic_cnt   <= r_rd_cnt;
                r_vic_rank  <= r_rd_rank;
                r_vic_key   <= r_rd_key;
            end
        end
        if (r_state == ST_DECIDE) begin
            r_res      <= w_res;
            r_slot     <= w_slot;
            r_old_rank <= w_old_rank;
            r_all      <= w_all;
        end
        if (w_out_load) begin
            r_out_word <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

FILE: src/lfu_lru_checker.sv
// ----------------------------------------------------------------------------
// lfu_lru_checker
// Port-level checks on LFU cache input and result channels, bound to top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfu_lru_checker (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    input  wire                    o_in_stall,
    input  wire                    o_out_valid,
    input  wire                    i_out_stall,
    input  lfu_lru_pkg::t_out_word o_out_word
);
    import lfu_lru_pkg::*;

    // held result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // one word in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after accept");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.hit |-> o_out_word.read_value == '0)
        else $error("miss with nonzero read value");

    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.evicted |-> !o_out_word.hit)
        else $error("eviction reported on a hit");

    a_evkey_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.evicted |-> o_out_word.evicted_key == '0)
        else $error("evicted key without eviction");

endmodule

bind lfu_cache_lru_tiebreak_top lfu_lru_checker u_lfu_lru_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

`default_nettype wire

FILE: tb/lfu_cache_checker.sv
// ----------------------------------------------------------------------------
// lfu_cache_checker
// Passive scoreboard for the LFU cache with LRU tie-break. It tracks its own
// copy of the cache from every accepted input word and capacity write, then
// compares each accepted result word with the oldest predicted outcome.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfu_cache_checker #(
    parameter int ENTRIES     = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    input  wire                          i_in_stall,
    input  lfu_lru_pkg::t_in_word        i_in_word,
    input  wire                          i_out_valid,
    input  wire                          i_out_stall,
    input  lfu_lru_pkg::t_out_word       i_out_word,
    input  wire                          i_cfg_we,
    input  wire [lfu_lru_pkg::CAP_W-1:0] i_cfg_wdata,
    output int                           o_errors,
    output int                           o_outstanding,
    output int                           o_checked,
    output int                           o_hits,
    output int                           o_evictions
);
    import lfu_lru_pkg::*;

    // shadow cache
    logic                   slot_valid [ENTRIES];
    logic [KEY_W-1:0]       slot_key   [ENTRIES];
    logic [DATA_W-1:0]      slot_value [ENTRIES];
    logic [COUNT_WIDTH-1:0] slot_uses  [ENTRIES];
    int                     slot_age   [ENTRIES];  // 0 = most recent
    int                     slots_used;
    logic [CAP_W-1:0]       capacity;

    t_out_word predicted_outcomes[$];

    initial begin
        o_errors      = 0;
        o_outstanding = 0;
        o_checked     = 0;
        o_hits        = 0;
        o_evictions   = 0;
    end

    // Slot s becomes newest; anything newer than its old age gets one older.
    function automatic void promote(int s, int old_age);
        int j;
        for (j = 0; j < ENTRIES; j++) begin
            if (j != s && slot_valid[j] && slot_age[j] < old_age)
                slot_age[j]++;
        end
        slot_age[s] = 0;
    endfunction

    function automatic t_out_word lookup_outcome(t_in_word w);
        t_out_word r;
        int        eff_cap;
        int        found;
        int        slot;
        int        j;
        r       = '0;
        eff_cap = (capacity > ENTRIES) ? ENTRIES : capacity;
        if (eff_cap != 0) begin
            found = -1;
            for (j = 0; j < ENTRIES; j++) begin
                if (found < 0 && slot_valid[j] && slot_key[j] == w.lookup_key)
                    found = j;
            end
            if (found >= 0) begin
                r.hit = 1'b1;
                if (w.action == ACT_PUT)
                    slot_value[found] = w.write_value;
                else
                    r.read_value = slot_value[found];
                if (slot_uses[found] != '1)
                    slot_uses[found]++;
                promote(found, slot_age[found]);
            end else if (w.action == ACT_PUT) begin
                slot = -1;
                if (slots_used < eff_cap) begin
                    for (j = 0; j < ENTRIES; j++) begin
                        if (slot < 0 && !slot_valid[j])
                            slot = j;
                    end
                end
                if (slot < 0) begin
                    // victim: fewest uses, oldest among equals
                    for (j = 0; j < ENTRIES; j++) begin
                        if (slot_valid[j] && (slot < 0 || slot_uses[j] < slot_uses[slot] ||
                            (slot_uses[j] == slot_uses[slot] && slot_age[j] > slot_age[slot])))
                            slot = j;
                    end
                    if (slot >= 0) begin
                        r.evicted     = 1'b1;
                        r.evicted_key = slot_key[slot];
                        for (j = 0; j < ENTRIES; j++) begin
                            if (j != slot && slot_valid[j] && slot_age[j] > slot_age[slot])
                                slot_age[j]--;
                        end
                        slot_valid[slot] = 1'b0;
                        if (slots_used > 0)
                            slots_used--;
                    end
                end
                if (slot >= 0) begin
                    slot_valid[slot] = 1'b1;
                    slot_key[slot]   = w.lookup_key;
                    slot_value[slot] = w.write_value;
                    slot_uses[slot]  = 1;
                    promote(slot, ENTRIES);
                    slots_used++;
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        int        j;
        if (!i_rst_n) begin
            for (j = 0; j < ENTRIES; j++)
                slot_valid[j] = 1'b0;
            slots_used = 0;
            capacity   = CAP_RESET;
            predicted_outcomes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (predicted_outcomes.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: unexpected result word hit=%b rd=%h ev=%b evk=%h",
                                 $realtime, i_out_word.hit, i_out_word.read_value,
                                 i_out_word.evicted, i_out_word.evicted_key);
                    o_errors++;
                end else begin
                    want = predicted_outcomes.pop_front();
                    o_checked++;
                    if (want.hit)
                        o_hits++;
                    if (want.evicted)
                        o_evictions++;
                    if (i_out_word.hit !== want.hit ||
                        i_out_word.read_value !== want.read_value ||
                        i_out_word.evicted !== want.evicted ||
                        i_out_word.evicted_key !== want.evicted_key) begin
                        if (o_errors < 10)
                            $display({"%0t: result %0d mismatch: expected hit=%b rd=%h ev=%b",
                                      " evk=%h, got hit=%b rd=%h ev=%b evk=%h"},
                                     $realtime, o_checked, want.hit, want.read_value,
                                     want.evicted, want.evicted_key, i_out_word.hit,
                                     i_out_word.read_value, i_out_word.evicted,
                                     i_out_word.evicted_key);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                predicted_outcomes.push_back(lookup_outcome(i_in_word));
            if (i_cfg_we)
                capacity = i_cfg_wdata;
        end
        o_outstanding = predicted_outcomes.size();
    end

endmodule

FILE: tb/lfu_cache_lru_tiebreak_top_tb.sv
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak_top_tb
// Drives get/put words and capacity writes into the LFU cache with random
// gaps on the input and random stalls on the output; the checker beside the
// block predicts every result. Directed words first, then random phases over
// several capacities, including disabled, oversized and shrunk caches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfu_cache_lru_tiebreak_top_tb;
    import lfu_lru_pkg::*;

    localparam int ENTRIES  = 16;
    localparam int CNT_W    = 4;       // narrow counts so saturation is reached
    localparam int SETTLE   = 2 * ENTRIES + 8;
    localparam int LIMIT    = 400000;
    localparam int MAX_GAP  = 18;
    localparam int POOL_MAX = 32;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    t_in_word         in_word   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out_word        out_word;
    logic             cfg_we    = 1'b0;
    logic [CAP_W-1:0] cfg_wdata = '0;

    int errors;
    int outstanding;
    int checked;
    int hits;
    int evictions;

    int        cycle_count    = 0;
    int        settings_count = 0;
    bit        quiet          = 1'b0;  // no gaps or stalls while set
    logic [31:0] key_pool [POOL_MAX];

    always #4 clk = ~clk;

    lfu_cache_lru_tiebreak_top #(
        .ENTRIES     (ENTRIES),
        .COUNT_WIDTH (CNT_W)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    lfu_cache_checker #(
        .ENTRIES     (ENTRIES),
        .COUNT_WIDTH (CNT_W)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_word     (in_word),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_word    (out_word),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .o_errors      (errors),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_hits        (hits),
        .o_evictions   (evictions)
    );

    function automatic int draw_gap();
        if (quiet)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Present one word after a random gap; returns in the step it is taken.
    task automatic send_word(input t_in_word w);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_count++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Receiver: per word either takes it at once or holds it for a while.
    initial begin
        int n;
        forever begin
            n = draw_gap();
            if (n > 0) begin
                out_stall <= 1'b1;
                do @(posedge clk); while (!out_valid);
                repeat (n - 1) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_in_word    w;
        int          k;
        int          p;
        int          n_items;
        int          pool_n;
        int          eff_cap;
        logic [CAP_W-1:0] cap;
        int          phase_caps [10] = '{16, 1, 31, 5, 0, 16, 2, 99, 8, 16};

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (k = 4; k < POOL_MAX; k++)
            key_pool[k] = $urandom();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty miss, extreme keys and values, update, fill, evict
        send_word(t_in_word'{ACT_GET, 32'sh0000_0000, 32'sh1234_5678});
        send_word(t_in_word'{ACT_PUT, 32'sh8000_0000, 32'sh7FFF_FFFF});
        send_word(t_in_word'{ACT_PUT, 32'sh7FFF_FFFF, 32'sh8000_0000});
        send_word(t_in_word'{ACT_GET, 32'sh8000_0000, 32'sh0000_0000});
        send_word(t_in_word'{ACT_PUT, 32'sh7FFF_FFFF, 32'sh0000_0000});
        send_word(t_in_word'{ACT_PUT, 32'shFFFF_FFFF, 32'shFFFF_FFFF});
        send_word(t_in_word'{ACT_GET, 32'sh0000_0000, 32'shFFFF_FFFF});
        for (k = 1; k <= 13; k++)
            send_word(t_in_word'{ACT_PUT, k, k * 3});
        send_word(t_in_word'{ACT_PUT, 100, 32'sh5555_AAAA});  // full: evicts
        // shrink below occupancy: a new key still evicts exactly one
        set_capacity(5'd3);
        send_word(t_in_word'{ACT_PUT, 200, 32'shAAAA_5555});
        // disabled: entries stay but are invisible
        set_capacity(5'd0);
        send_word(t_in_word'{ACT_GET, 5, 0});
        send_word(t_in_word'{ACT_PUT, 300, 1});
        // above ENTRIES acts as a full-size cache; old entries visible again
        set_capacity(5'd31);
        send_word(t_in_word'{ACT_GET, 5, 0});

        // random phases, one capacity each
        for (p = 0; p < 10; p++) begin
            cap = (phase_caps[p] > 31) ? CAP_W'($urandom_range(0, 31)) : CAP_W'(phase_caps[p]);
            set_capacity(cap);
            eff_cap = (cap > ENTRIES) ? ENTRIES : cap;
            pool_n  = eff_cap + $urandom_range(1, 8);
            n_items = (eff_cap == 0) ? 20 : 75;
            for (k = 0; k < n_items; k++) begin
                if (k % 25 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                w.action      = t_action'($urandom_range(0, 1));
                w.lookup_key  = ($urandom_range(0, 4) == 0) ? $urandom()
                                                            : key_pool[$urandom_range(0, pool_n - 1)];
                w.write_value = pick_value();
                send_word(w);
            end
        end

        quiet = 1'b0;
        drain();
        $display("Checked %0d result words: %0d hits, %0d evictions, %0d capacity writes",
                 checked, hits, evictions, settings_count);
        $display("Covered miss on empty, updates, full and shrunk eviction, disabled cache");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
